[rtl/core/msp_pkg.sv]
// Mode S preamble detector package: widths, window type, phase codes, result struct.
// Depends on nothing; every other file of the block uses it by scoped name.
package msp_pkg;

  localparam int SampleW    = 16;  // width of the sample field on the port
  localparam int SampleBits = 16;  // bits of a sample that are kept (8..16)
  localparam int WinLen     = 19;  // sliding window length
  localparam int FillW      = $clog2(WinLen + 1);
  localparam int LevelW     = 17;
  localparam int SumW       = 19;  // holds a sum of six 16-bit samples
  localparam int CmpW       = 20;  // holds 3 * noise and 2 * signal
  localparam int PhaseW     = 3;
  localparam int QuietN     = 9;
  localparam int QuietIdx [QuietN] = '{5, 6, 7, 8, 14, 15, 16, 17, 18};

  typedef logic [WinLen-1:0][SampleBits-1:0] win_t;  // index 0 is the oldest

  typedef enum logic [PhaseW-1:0] {
    Phase3 = 3'd0,
    Phase4 = 3'd1,
    Phase5 = 3'd2,
    Phase6 = 3'd3,
    Phase7 = 3'd4
  } phase_e;

  typedef struct packed {
    logic              window_full;
    logic              detected;
    logic [PhaseW-1:0] phase_class;
    logic [LevelW-1:0] level;
  } result_t;

endpackage

[rtl/core/msp_sample_if.sv]
// Sample channel of the Mode S preamble detector: valid/ready plus one sample.
// Depends on msp_pkg.
interface msp_sample_if;
  logic                        valid;
  logic                        ready;
  logic [msp_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[rtl/core/msp_result_if.sv]
// Result channel of the Mode S preamble detector: valid/ready plus result fields.
// Depends on msp_pkg.
interface msp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       window_full;
  logic                       detected;
  logic [msp_pkg::PhaseW-1:0] phase_class;
  logic [msp_pkg::LevelW-1:0] level;

  modport source (output valid, output window_full, output detected,
                  output phase_class, output level, input ready);
  modport sink   (input valid, input window_full, input detected,
                  input phase_class, input level, output ready);
endinterface

[rtl/core/msp_window.sv]
// 19-sample sliding window with saturating fill count.
// Depends on msp_pkg.
module msp_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic [msp_pkg::SampleW-1:0]         sample_i,
  output msp_pkg::win_t                       win_o,
  output logic                                full_o
);

  msp_pkg::win_t                  win_q, win_d;
  logic [msp_pkg::FillW-1:0]      fill_q, fill_d;
  logic                           full;

  assign full = (fill_q == msp_pkg::FillW'(msp_pkg::WinLen));

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (push_i) begin
      // newest sample enters at the top, oldest drops out of index 0
      win_d = {sample_i[msp_pkg::SampleBits-1:0], win_q[msp_pkg::WinLen-1:1]};
      if (!full) begin
        fill_d = fill_q + msp_pkg::FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

  assign win_o  = win_q;
  assign full_o = full;

endmodule

[rtl/core/msp_match.sv]
// Preamble evaluation over one window: edges, five phase patterns, level, SNR, quiet.
// Depends on msp_pkg.
module msp_match (
  input  msp_pkg::win_t   win_i,
  input  logic            full_i,
  output msp_pkg::result_t res_o
);

  logic [msp_pkg::SumW-1:0]   p [msp_pkg::WinLen];
  logic [msp_pkg::SumW-1:0]   lvl_sum, sig, noi;
  logic [msp_pkg::LevelW-1:0] lvl;
  logic [msp_pkg::CmpW-1:0]   sig2, noi3;
  logic [msp_pkg::SumW-1:0]   th;
  msp_pkg::phase_e            cls;
  logic                       matched, edges_ok, snr_ok, quiet_ok;
  logic a12, q23, b23, c34, m34, h45, d89, n910, e910, k1011, f1011, g1112;

  always_comb begin
    for (int i = 0; i < msp_pkg::WinLen; i++) begin
      p[i] = msp_pkg::SumW'(win_i[i]);
    end
  end

  // neighbor compares, most of them shared by several patterns
  assign a12   = p[1]  > p[2];
  assign q23   = p[2]  > p[3];
  assign b23   = p[2]  < p[3];
  assign c34   = p[3]  > p[4];
  assign m34   = p[3]  < p[4];
  assign h45   = p[4]  > p[5];
  assign d89   = p[8]  < p[9];
  assign n910  = p[9]  < p[10];
  assign e910  = p[9]  > p[10];
  assign k1011 = p[10] > p[11];
  assign f1011 = p[10] < p[11];
  assign g1112 = p[11] < p[12];

  assign edges_ok = full_i && (p[0] < p[1]) && (p[12] > p[13]);

  // first matching pattern wins
  always_comb begin
    matched = 1'b1;
    cls     = msp_pkg::Phase3;
    lvl_sum = '0;
    sig     = '0;
    noi     = '0;
    priority if (a12 && b23 && c34 && d89 && e910 && f1011) begin
      cls     = msp_pkg::Phase3;
      lvl_sum = p[1] + p[3] + p[9] + p[11] + p[12];
      sig     = p[1] + p[3] + p[9];
      noi     = p[5] + p[6] + p[7];
    end else if (a12 && b23 && c34 && d89 && e910 && g1112) begin
      cls     = msp_pkg::Phase4;
      lvl_sum = p[1] + p[3] + p[9] + p[12];
      sig     = p[1] + p[3] + p[9] + p[12];
      noi     = p[5] + p[6] + p[7] + p[8];
    end else if (a12 && b23 && h45 && d89 && k1011 && g1112) begin
      cls     = msp_pkg::Phase5;
      lvl_sum = p[1] + p[3] + p[4] + p[9] + p[10] + p[12];
      sig     = p[1] + p[12];
      noi     = p[6] + p[7];
    end else if (a12 && m34 && h45 && n910 && k1011 && g1112) begin
      cls     = msp_pkg::Phase6;
      lvl_sum = p[1] + p[4] + p[10] + p[12];
      sig     = p[1] + p[4] + p[10] + p[12];
      noi     = p[5] + p[6] + p[7] + p[8];
    end else if (q23 && m34 && h45 && n910 && k1011 && g1112) begin
      cls     = msp_pkg::Phase7;
      lvl_sum = p[1] + p[2] + p[4] + p[10] + p[12];
      sig     = p[4] + p[10] + p[12];
      noi     = p[6] + p[7] + p[8];
    end else begin
      matched = 1'b0;
    end
  end

  assign lvl  = lvl_sum[msp_pkg::SumW-1:2];
  assign sig2 = msp_pkg::CmpW'(sig) << 1;
  assign noi3 = msp_pkg::CmpW'(noi) + (msp_pkg::CmpW'(noi) << 1);
  assign snr_ok = sig2 >= noi3;

  // quiet test against the level's low 16 bits
  assign th = msp_pkg::SumW'(lvl[15:0]);
  always_comb begin
    quiet_ok = 1'b1;
    for (int i = 0; i < msp_pkg::QuietN; i++) begin
      if (p[msp_pkg::QuietIdx[i]] >= th) quiet_ok = 1'b0;
    end
  end

  always_comb begin
    res_o.window_full = full_i;
    res_o.detected    = 1'b0;
    res_o.phase_class = '0;
    res_o.level       = '0;
    if (edges_ok && matched) begin
      res_o.detected    = snr_ok && quiet_ok;
      res_o.phase_class = cls;
      res_o.level       = lvl;
    end
  end

endmodule

[rtl/core/mode_s_preamble_detector.sv]
// Mode S preamble detector top level: window register, evaluation, result register.
// Depends on msp_pkg, msp_sample_if, msp_result_if, msp_window, msp_match.
//
// Usage:
//   sample_i carries one 16-bit magnitude sample per beat (2.4 MS/s stream).
//   result_o carries one result beat per sample beat, in order: window_full,
//   detected, phase_class (0..4 = phases 3..7) and the 17-bit level.
//   Until 19 samples have arrived, window_full is 0 and the other fields are 0.
// Timing:
//   A sample accepted on sample_i shifts into the window register; its result is
//   evaluated combinationally from that register and loaded into the result
//   register when that register is free or draining, from where it leaves as
//   a result beat. One sample per cycle is sustained while result_o.ready
//   stays high: the window register and the result register form a two-stage
//   pipeline, and the evaluation between them is a single pass of compares,
//   adders and a mux.
// Reset:
//   rst_ni clears the window, the fill count and both stage valid flags.
// Back-pressure:
//   When result_o.ready is low the result register holds its beat; the window
//   stage still takes a sample if it is empty, then sample_i.ready drops until
//   the result register frees up. No beat is lost or repeated.
module mode_s_preamble_detector (
  input  logic              clk_i,
  input  logic              rst_ni,
  msp_sample_if.sink        sample_i,
  msp_result_if.source      result_o
);

  msp_pkg::win_t    win;
  logic             full;
  msp_pkg::result_t res;
  msp_pkg::result_t out_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_adv, in_ready, in_beat;

  // result register free or draining this cycle
  assign out_adv  = !out_valid_q || result_o.ready;
  assign in_ready = !s1_valid_q || out_adv;
  assign in_beat  = sample_i.valid && in_ready;

  assign sample_i.ready = in_ready;

  msp_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_beat),
    .sample_i (sample_i.sample),
    .win_o    (win),
    .full_o   (full)
  );

  msp_match u_match (
    .win_i  (win),
    .full_i (full),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_beat) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.window_full = out_q.window_full;
  assign result_o.detected    = out_q.detected;
  assign result_o.phase_class = out_q.phase_class;
  assign result_o.level       = out_q.level;

  // a detection never comes from a partly filled window
  a_det_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.detected |-> out_q.window_full)
    else $error("detection reported before window full");

  // partly filled window reports no pattern and no level
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.window_full |-> (out_q.level == '0) && (out_q.phase_class == '0))
    else $error("nonzero fields before window full");

  // an accepted sample occupies the window stage next cycle
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> s1_valid_q)
    else $error("accepted sample lost in window stage");

  // a new result beat always comes from a pending window stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result beat without source sample");

endmodule
